>>> sv/assert_macros.svh
// assertion macros for the key matrix port resolver top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, disabled while reset is held
`define KPR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kpr assertion failed");
// checked property that also runs through reset
`define KPR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("kpr assertion failed");
`else
`define KPR_ASSERT(label, clk, rst_n, prop)
`define KPR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> sv/kpr_pkg.sv
// types, constants and round function for the key matrix port resolver
package kpr_pkg;

  localparam int ROUNDS_DEF    = 8;
  localparam int FORCE_MARGIN  = 3;
  localparam int LIGHT_PEN_BIT = 4;

  // pin state of one evaluation: strong-1 masks and level masks
  typedef struct packed {
    logic [7:0] a_hi;
    logic [7:0] a_lo;
    logic [7:0] b_hi;
    logic [7:0] b_lo;
  } kpr_eval_t;

  // everything one transaction carries down the chain of cells
  typedef struct packed {
    logic [63:0] key_matrix;
    logic [7:0]  joy_a;
    logic [7:0]  joy_b;
    kpr_eval_t   eval_frc;
    kpr_eval_t   eval_nrm;
  } kpr_item_t;

  typedef struct packed {
    logic [7:0] port_a;
    logic [7:0] port_b;
  } kpr_res_t;

  function automatic logic [3:0] kpr_pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + 4'(v[k]);
    end
    return n;
  endfunction

  // active-low column c of the key matrix, one bit per row
  function automatic logic [7:0] kpr_col(input logic [63:0] km, input int c);
    logic [7:0] v;
    for (int r = 0; r < 8; r++) begin
      v[r] = km[r*8 + c];
    end
    return v;
  endfunction

  // one contention round: column pass, then row pass on the updated port b
  function automatic kpr_eval_t kpr_round(input logic [63:0] km, input kpr_eval_t cur,
                                          input logic frc_high);
    kpr_eval_t  e;
    logic [7:0] held;
    logic [3:0] n0;
    logic [3:0] n1;
    e = cur;
    for (int c = 0; c < 8; c++) begin
      held = ~kpr_col(km, c);
      n0   = kpr_pop8(~cur.a_lo & held);
      if (n0 != 4'd0 && (!cur.b_hi[c] || n0 >= 4'(FORCE_MARGIN))) begin
        e.b_lo[c] = 1'b0;
        e.b_hi[c] = 1'b0;
      end
    end
    for (int r = 0; r < 8; r++) begin
      held = ~km[r*8 +: 8];
      n0   = kpr_pop8(~e.b_lo & held);
      n1   = kpr_pop8(e.b_hi & held);
      if (n0 > n1) begin
        e.a_lo[r] = 1'b0;
        e.a_hi[r] = 1'b0;
      end
      if (frc_high && ({1'b0, n1} >= ({1'b0, n0} + 5'(FORCE_MARGIN)))) begin
        e.a_lo[r] = 1'b1;
        e.a_hi[r] = 1'b1;
      end
    end
    return e;
  endfunction

endpackage

>>> sv/key_matrix_port_resolver_top.sv
// top level of the key matrix port resolver: cell chain and output buffer
//
// Usage:
//   The input channel (in_valid / in_stall) takes one transaction with the held-key
//   matrix, both ports' drive masks and the joystick lines. The output channel
//   (out_valid / out_stall) returns port A and port B levels and the light-pen line.
//   Each transaction passes a chain of ROUNDS round cells, one contention round per
//   cell, then an output register. Throughput is one transaction per cycle while
//   in_stall is low; every cell hands its transaction to the next one each cycle
//   unless the chain holds.
//   When the receiver stalls, one more transaction is parked in a skid register;
//   once that is full, in_stall rises and the whole chain holds until the output
//   is taken. in_stall is a register and does not follow out_stall combinationally.
//   Synchronous active-low reset empties the chain and the output buffer; no other
//   state is kept between transactions.
`include "assert_macros.svh"

module key_matrix_port_resolver_top import kpr_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_key_matrix,
  input  logic [7:0]  in_port_a_drive_high,
  input  logic [7:0]  in_port_a_drive_low_n,
  input  logic [7:0]  in_port_b_drive_high,
  input  logic [7:0]  in_port_b_drive_low_n,
  input  logic [7:0]  in_joy_on_a,
  input  logic [7:0]  in_joy_on_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_port_a_level,
  output logic [7:0]  out_port_b_level,
  output logic        out_light_pen_line
);

  logic [ROUNDS:0] stage_valid;
  kpr_item_t       stage_item [ROUNDS+1];
  kpr_eval_t       eval_init;
  kpr_res_t        chain_res;
  kpr_res_t        out_res;
  logic            chain_en;

  // drive masks are gated by the joystick pull-downs before the first round
  always_comb begin
    eval_init.a_hi = in_port_a_drive_high  & in_joy_on_a;
    eval_init.a_lo = in_port_a_drive_low_n & in_joy_on_a;
    eval_init.b_hi = in_port_b_drive_high  & in_joy_on_b;
    eval_init.b_lo = in_port_b_drive_low_n & in_joy_on_b;
  end

  assign stage_valid[0]           = in_valid;
  assign stage_item[0].key_matrix = in_key_matrix;
  assign stage_item[0].joy_a      = in_joy_on_a;
  assign stage_item[0].joy_b      = in_joy_on_b;
  assign stage_item[0].eval_frc   = eval_init;
  assign stage_item[0].eval_nrm   = eval_init;

  for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
    kpr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (chain_en),
      .in_valid  (stage_valid[k]),
      .in_item   (stage_item[k]),
      .out_valid (stage_valid[k+1]),
      .out_item  (stage_item[k+1])
    );
  end

  // port a from the forcing evaluation, port b from the plain one
  assign chain_res.port_a = stage_item[ROUNDS].eval_frc.a_lo & stage_item[ROUNDS].joy_a;
  assign chain_res.port_b = stage_item[ROUNDS].eval_nrm.b_lo & stage_item[ROUNDS].joy_b;

  kpr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stage_valid[ROUNDS]),
    .in_res    (chain_res),
    .chain_en  (chain_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign in_stall           = !chain_en;
  assign out_port_a_level   = out_res.port_a;
  assign out_port_b_level   = out_res.port_b;
  assign out_light_pen_line = out_res.port_b[LIGHT_PEN_BIT];

  // a parked transaction means the output register is occupied
  `KPR_ASSERT(a_stall_has_output, clk, rst_n, in_stall |-> out_valid)
  // input stall only rises after the receiver held a transaction
  `KPR_ASSERT(a_stall_rise_cause, clk, rst_n, $rose(in_stall) |-> $past(out_valid && out_stall))
  // reset leaves both sides empty
  `KPR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid && !in_stall))

endmodule

>>> sv/kpr_cell.sv
// one contention round cell, runs both evaluations and registers the result
module kpr_cell import kpr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  kpr_item_t in_item,
  output logic      out_valid,
  output kpr_item_t out_item
);

  logic      valid_r;
  kpr_item_t item_r;
  kpr_item_t item_nxt;

  always_comb begin
    item_nxt          = in_item;
    item_nxt.eval_frc = kpr_round(in_item.key_matrix, in_item.eval_frc, 1'b1);
    item_nxt.eval_nrm = kpr_round(in_item.key_matrix, in_item.eval_nrm, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> sv/kpr_out_buf.sv
// output register with skid stage between the cell chain and the receiver
module kpr_out_buf import kpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  kpr_res_t in_res,
  output logic     chain_en,
  output logic     out_valid,
  input  logic     out_stall,
  output kpr_res_t out_res
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_full_r, skid_full_nxt;
  kpr_res_t out_res_r, out_res_nxt;
  kpr_res_t skid_r, skid_nxt;
  logic     take;
  logic     push;

  assign take     = out_valid_r && !out_stall;
  assign chain_en = !skid_full_r;
  assign push     = chain_en && in_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_res_nxt   = out_res_r;
    skid_nxt      = skid_r;
    if (skid_full_r) begin
      if (take) begin
        out_res_nxt   = skid_r;
        skid_full_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_res_nxt   = in_res;
        out_valid_nxt = 1'b1;
      end else begin
        // receiver holds the current transaction, park the new one
        skid_nxt      = in_res;
        skid_full_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    skid_r    <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> tb/sv/key_matrix_port_resolver_top_tb.sv
// self-checking testbench for the key matrix port resolver top level
module key_matrix_port_resolver_top_tb;
  import kpr_pkg::*;

  typedef struct packed {
    logic [63:0] keys;
    logic [7:0]  a_high;
    logic [7:0]  a_low_n;
    logic [7:0]  b_high;
    logic [7:0]  b_low_n;
    logic [7:0]  joy_a;
    logic [7:0]  joy_b;
  } port_read_t;

  typedef struct packed {
    logic [7:0] port_a;
    logic [7:0] port_b;
    logic       light_pen;
  } pin_levels_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_key_matrix = '1;
  logic [7:0]  in_port_a_drive_high = '0;
  logic [7:0]  in_port_a_drive_low_n = '1;
  logic [7:0]  in_port_b_drive_high = '0;
  logic [7:0]  in_port_b_drive_low_n = '1;
  logic [7:0]  in_joy_on_a = '1;
  logic [7:0]  in_joy_on_b = '1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_port_a_level;
  logic [7:0]  out_port_b_level;
  logic        out_light_pen_line;

  pin_levels_t pending_levels[$];
  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int          hold_req = 0;
  int          reads_sent = 0;
  int          levels_seen = 0;
  int          errors = 0;

  key_matrix_port_resolver_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_key_matrix        (in_key_matrix),
    .in_port_a_drive_high (in_port_a_drive_high),
    .in_port_a_drive_low_n(in_port_a_drive_low_n),
    .in_port_b_drive_high (in_port_b_drive_high),
    .in_port_b_drive_low_n(in_port_b_drive_low_n),
    .in_joy_on_a          (in_joy_on_a),
    .in_joy_on_b          (in_joy_on_b),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_port_a_level     (out_port_a_level),
    .out_port_b_level     (out_port_b_level),
    .out_light_pen_line   (out_light_pen_line)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int ones8(input logic [7:0] v);
    int n;
    n = 0;
    for (int k = 0; k < 8; k++) n += int'(v[k]);
    return n;
  endfunction

  // run all contention rounds of one evaluation
  function automatic void contend(input logic [63:0] km, input logic [7:0] a_hi_in,
                                  input logic [7:0] a_lo_in, input logic [7:0] b_hi_in,
                                  input logic [7:0] b_lo_in, input bit force_high,
                                  output logic [7:0] a_res, output logic [7:0] b_res);
    logic [7:0] a_hi, a_lo, b_hi, b_lo, held;
    int n0, n1;
    a_hi = a_hi_in;
    a_lo = a_lo_in;
    b_hi = b_hi_in;
    b_lo = b_lo_in;
    for (int rnd = 0; rnd < ROUNDS_DEF; rnd++) begin
      for (int c = 0; c < 8; c++) begin
        for (int r = 0; r < 8; r++) held[r] = ~km[r*8 + c];
        n0 = ones8(~a_lo & held);
        // a strong 1 on the column needs three low rows to lose
        if (held != 8'h00 && n0 > 0 && n0 >= (b_hi[c] ? FORCE_MARGIN : 0)) begin
          b_lo[c] = 1'b0;
          b_hi[c] = 1'b0;
        end
      end
      for (int r = 0; r < 8; r++) begin
        held = ~km[r*8 +: 8];
        n0 = ones8(~b_lo & held);
        n1 = ones8(b_hi & held);
        if (n0 > n1) begin
          a_lo[r] = 1'b0;
          a_hi[r] = 1'b0;
        end
        if (force_high && held != 8'h00 && n1 >= n0 + FORCE_MARGIN) begin
          a_lo[r] = 1'b1;
          a_hi[r] = 1'b1;
        end
      end
    end
    a_res = a_lo;
    b_res = b_lo;
  endfunction

  function automatic pin_levels_t resolve_ports(input port_read_t rd);
    pin_levels_t lv;
    logic [7:0]  a_frc, b_frc, a_nrm, b_nrm;
    contend(rd.keys, rd.a_high & rd.joy_a, rd.a_low_n & rd.joy_a, rd.b_high & rd.joy_b,
            rd.b_low_n & rd.joy_b, 1'b1, a_frc, b_frc);
    contend(rd.keys, rd.a_high & rd.joy_a, rd.a_low_n & rd.joy_a, rd.b_high & rd.joy_b,
            rd.b_low_n & rd.joy_b, 1'b0, a_nrm, b_nrm);
    lv.port_a    = a_frc & rd.joy_a;
    lv.port_b    = b_nrm & rd.joy_b;
    lv.light_pen = lv.port_b[LIGHT_PEN_BIT];
    return lv;
  endfunction

  function automatic port_read_t make_read(input logic [63:0] km, input logic [7:0] ah,
                                           input logic [7:0] al, input logic [7:0] bh,
                                           input logic [7:0] bl, input logic [7:0] ja,
                                           input logic [7:0] jb);
    port_read_t rd;
    rd.keys    = km;
    rd.a_high  = ah;
    rd.a_low_n = al;
    rd.b_high  = bh;
    rd.b_low_n = bl;
    rd.joy_a   = ja;
    rd.joy_b   = jb;
    return rd;
  endfunction

  // key matrix with each key held at the given rate out of 16
  function automatic logic [63:0] rand_keys(input int rate);
    logic [63:0] km;
    for (int k = 0; k < 64; k++) km[k] = ($urandom_range(0, 15) >= rate);
    return km;
  endfunction

  function automatic port_read_t rand_read();
    logic [63:0] km;
    if ($urandom_range(0, 3) == 0) km = {$urandom, $urandom};
    else km = rand_keys($urandom_range(1, 4));
    // joystick lines mostly released so the matrix decides
    return make_read(km, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hff,
                     ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hff);
  endfunction

  task automatic send_read(input port_read_t rd);
    in_key_matrix         <= rd.keys;
    in_port_a_drive_high  <= rd.a_high;
    in_port_a_drive_low_n <= rd.a_low_n;
    in_port_b_drive_high  <= rd.b_high;
    in_port_b_drive_low_n <= rd.b_low_n;
    in_joy_on_a           <= rd.joy_a;
    in_joy_on_b           <= rd.joy_b;
    in_valid              <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_levels.push_back(resolve_ports(rd));
    reads_sent++;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver: random stall bursts, or a long hold-off on request
  initial begin : sink_proc
    int burst;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        burst = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : level_check
    pin_levels_t exp_lv;
    if (rst_n && out_valid && !out_stall) begin
      levels_seen++;
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual a=%0h b=%0h", $time,
                 out_port_a_level, out_port_b_level);
        errors++;
      end else begin
        exp_lv = pending_levels.pop_front();
        check_field("port_a_level", exp_lv.port_a, out_port_a_level);
        check_field("port_b_level", exp_lv.port_b, out_port_b_level);
        check_field("light_pen_line", {7'b0, exp_lv.light_pen}, {7'b0, out_light_pen_line});
      end
    end
  end

  task automatic test_no_keys();
    send_read(make_read('1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_read(make_read('1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_read(make_read('1, 8'h3c, 8'h96, 8'hc3, 8'h69, 8'ha5, 8'h5a));
  endtask

  task automatic test_full_matrix();
    send_read(make_read('0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_read(make_read('0, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
    // contradictory drive: strong 1 and strong 0 on the same pins
    send_read(make_read('0, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff));
    send_read(make_read('0, 8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff));
  endtask

  task automatic test_contention_rules();
    // single key, low row pulls its column low
    send_read(make_read(64'hffff_ffff_ffdf_ffff, 8'h00, 8'hfb, 8'h00, 8'hff, 8'hff, 8'hff));
    // single low row cannot beat a strong 1 column
    send_read(make_read(64'hffff_ffff_ffdf_ffff, 8'h00, 8'hfb, 8'h20, 8'hff, 8'hff, 8'hff));
    // three low rows do beat it
    send_read(make_read(64'hffff_ffff_fffe_fefe, 8'h00, 8'hf8, 8'h01, 8'hff, 8'hff, 8'hff));
    // four strong 1 columns force the row high
    send_read(make_read(64'hffff_ffff_ffff_fff0, 8'h00, 8'hfe, 8'h0f, 8'hff, 8'hff, 8'hff));
    // margin of one only, no force
    send_read(make_read(64'hffff_ffff_ffff_fff8, 8'h00, 8'hff, 8'h03, 8'hfb, 8'hff, 8'hff));
    // low columns pull the row low
    send_read(make_read(64'hffff_ffff_fcff_ffff, 8'hff, 8'hff, 8'h00, 8'hfc, 8'hff, 8'hff));
    // joystick lines pull pins low
    send_read(make_read(64'hffff_ffff_ffdf_ffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00));
    send_read(make_read(64'hffff_ffff_ffff_efff, 8'h00, 8'hfd, 8'h00, 8'hff, 8'hff, 8'hff));
    send_read(make_read(64'hffff_ffff_ffff_efff, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff));
    // low level travels through several rounds
    send_read(make_read(64'hffff_ffff_ffff_fcfe, 8'h00, 8'hfe, 8'h00, 8'hff, 8'hff, 8'hff));
    for (int k = 0; k < 8; k++) begin
      send_read(make_read(~(64'h1 << (k*9)), 8'h1 << k, ~(8'h1 << k), 8'h80 >> k,
                          ~(8'h80 >> k), 8'hff, 8'hff));
    end
  endtask

  task automatic test_random_reads();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (560) send_read(rand_read());
  endtask

  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 60;
    repeat (40) send_read(rand_read());
    // sender stops until every transaction is back
    wait_drained();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (10) send_read(rand_read());
  endtask

  task automatic test_full_rate();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (40) send_read(rand_read());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_keys();
    test_full_matrix();
    test_contention_rules();
    test_random_reads();
    test_backpressure();
    test_full_rate();
    wait_drained();
    repeat (ROUNDS_DEF + 8) @(posedge clk);
    if (pending_levels.size() != 0) errors++;
    $display("sent %0d port reads (directed, random, backpressure, full rate), checked %0d",
             reads_sent, levels_seen);
    $display("mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
